// File: rtl/dadm_pkg.sv
// Package with shared types, codes and defaults of the domain allow/deny matcher.
`timescale 1ns / 1ps
package dadm_pkg;

  localparam int MAX_ENTRIES_DEF     = 16;
  localparam int MAX_PATTERN_LEN_DEF = 64;
  localparam int DOMAIN_MAX_DEF      = 512;
  localparam logic [7:0] SEPARATOR   = 8'h20;

  typedef enum logic [1:0] {
    REQ_ALLOW_LOAD = 2'd0,
    REQ_DENY_LOAD  = 2'd1,
    REQ_DOMAIN     = 2'd2,
    REQ_UNUSED     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    HIT_NONE        = 3'd0,
    HIT_ALLOW_EXACT = 3'd1,
    HIT_ALLOW_SUB   = 3'd2,
    HIT_DENY_EXACT  = 3'd3,
    HIT_DENY_SUB    = 3'd4,
    HIT_ALLOW_MISS  = 3'd5
  } hit_t;

  localparam logic [2:0] CFG_ALLOW_ENABLE = 3'd0;
  localparam logic [2:0] CFG_ALLOW_MODE   = 3'd1;
  localparam logic [2:0] CFG_DENY_ENABLE  = 3'd2;
  localparam logic [2:0] CFG_DENY_MODE    = 3'd3;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       drop;
    logic [2:0] rule_hit;
    logic       overflow;
  } out_item_t;

  // Compare bus broadcast to every cell during a sweep.
  typedef struct packed {
    logic       clr;
    logic       act;
    logic       dv;
    logic [7:0] dbyte;
  } sweep_t;

endpackage

// File: rtl/dadm_cell.sv
// One pattern entry: its byte store, its length and its running match state.
`timescale 1ns / 1ps
module dadm_cell #(
  parameter int MAX_PATTERN_LEN = dadm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int DOMAIN_MAX      = dadm_pkg::DOMAIN_MAX_DEF,
  localparam int PAW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1,
  localparam int PLW = $clog2(MAX_PATTERN_LEN + 1),
  localparam int DLW = $clog2(DOMAIN_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [PAW-1:0]    wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              len_wr,
  input  logic [PLW-1:0]    len_data,
  input  logic              en,
  input  logic              substr,
  input  logic [DLW-1:0]    dlen,
  input  logic [PAW-1:0]    k_rd,
  input  logic [PAW-1:0]    k_cmp,
  input  dadm_pkg::sweep_t  sw,
  input  logic              hit_in,
  output logic              hit_out
);

  logic [7:0]     mem [MAX_PATTERN_LEN];
  logic [7:0]     pat_q;
  logic [PLW-1:0] plen;
  logic           cur;
  logic           hit;
  logic           in_range;
  logic           last_k;
  logic           m;
  logic           mode_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    pat_q <= mem[k_rd];
    if (len_wr) begin
      plen <= len_data;
    end
  end

  always_comb begin
    in_range = {{(PLW > PAW ? PLW - PAW : 0){1'b0}}, k_cmp} < plen;
    last_k   = {{(PLW > PAW ? PLW - PAW : 0){1'b0}}, k_cmp} == plen - PLW'(1);
    m        = ((k_cmp == '0) ? 1'b1 : cur) & sw.dv & (sw.dbyte == pat_q);
    mode_ok  = substr ? (plen != '0)
                      : (DLW'(plen) == dlen);
  end

  always_ff @(posedge clk) begin
    if (rst || sw.clr) begin
      cur     <= 1'b0;
      hit     <= 1'b0;
      hit_out <= 1'b0;
    end else begin
      if (sw.act && in_range) begin
        cur <= m;
        if (last_k && m && en && mode_ok) begin
          hit <= 1'b1;
        end
      end
      hit_out <= hit_in | hit;
    end
  end

endmodule

// File: rtl/dadm_chain.sv
// One pattern list: a row of entry cells whose hit flags ripple down the row.
`timescale 1ns / 1ps
module dadm_chain #(
  parameter int MAX_ENTRIES     = dadm_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_PATTERN_LEN = dadm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int DOMAIN_MAX      = dadm_pkg::DOMAIN_MAX_DEF,
  localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int ECW = $clog2(MAX_ENTRIES + 1),
  localparam int PAW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1,
  localparam int PLW = $clog2(MAX_PATTERN_LEN + 1),
  localparam int DLW = $clog2(DOMAIN_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              len_wr,
  input  logic [EIW-1:0]    wr_idx,
  input  logic [PAW-1:0]    wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [PLW-1:0]    len_data,
  input  logic [ECW-1:0]    count,
  input  logic              substr,
  input  logic [DLW-1:0]    dlen,
  input  logic [PAW-1:0]    k_rd,
  input  logic [PAW-1:0]    k_cmp,
  input  dadm_pkg::sweep_t  sw,
  output logic              hit
);

  logic [MAX_ENTRIES:0] link;

  assign link[0] = 1'b0;
  assign hit     = link[MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    dadm_cell #(
      .MAX_PATTERN_LEN(MAX_PATTERN_LEN),
      .DOMAIN_MAX     (DOMAIN_MAX)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (wr_en && (wr_idx == EIW'(i))),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .len_wr  (len_wr && (wr_idx == EIW'(i))),
      .len_data(len_data),
      .en      (ECW'(i) < count),
      .substr  (substr),
      .dlen    (dlen),
      .k_rd    (k_rd),
      .k_cmp   (k_cmp),
      .sw      (sw),
      .hit_in  (link[i]),
      .hit_out (link[i+1])
    );
  end

endmodule

// File: rtl/domain_allow_deny_matcher.sv
// Top level of the domain allow/deny matcher: loading, domain buffer, sweep control.
// A list byte is written into its entry when accepted. With a list enabled, a domain's
// last byte starts a sweep over every (offset, position) pair, with as many offsets as
// domain bytes in substring mode and one in exact mode; a drain lets hits ripple down
// the entries. Throughput: one non-final byte per cycle while idle, output free; the
// sweep sets the verdict time. Reset clears counts, flags and control registers.
`timescale 1ns / 1ps
module domain_allow_deny_matcher #(
  parameter int MAX_ENTRIES     = dadm_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_PATTERN_LEN = dadm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int DOMAIN_MAX      = dadm_pkg::DOMAIN_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dadm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dadm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic                cfg_data
);

  localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int PAW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int PLW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int DAW = $clog2(DOMAIN_MAX);
  localparam int DLW = $clog2(DOMAIN_MAX + 1);
  localparam int DRW = $clog2(MAX_ENTRIES + 5);

  // Configuration registers.
  logic allow_enable, allow_mode, deny_enable, deny_mode;

  // Load state: a count per list; position, busy and overflow flag shared by both lists.
  logic [ECW-1:0] allow_count, deny_count;
  logic [PLW-1:0] load_position;
  logic           load_busy;
  logic           overflow_seen;

  // Domain buffer.
  logic [7:0]     dbuf [DOMAIN_MAX];
  logic [DLW-1:0] domain_length;

  // Sweep control.
  dadm_pkg::state_t st, st_next;
  logic [DLW-1:0] off;
  logic [PAW-1:0] k, k1;
  logic           act1, dv1;
  logic [7:0]     dom_q;
  logic [DRW-1:0] drain;
  logic           sel_allow;
  logic           substr_sel;
  logic           sweep_end;
  logic [DLW:0]   addr;
  logic           clr;
  dadm_pkg::sweep_t sw;
  logic           allow_hit, deny_hit;

  // Accept decode.
  logic in_acc, is_load, is_allow, is_dom, is_sep;
  logic [ECW-1:0] cnt_sel, cnt_eff, cnt_new;
  logic [PLW-1:0] pos_eff;
  logic           pat_wr, len_wr, ovf_now;
  logic [PLW-1:0] pos_new;
  logic           verdict_go;
  dadm_pkg::out_item_t verdict;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == dadm_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign is_allow  = in_data.req_type == dadm_pkg::REQ_ALLOW_LOAD;
  assign is_load   = is_allow || (in_data.req_type == dadm_pkg::REQ_DENY_LOAD);
  assign is_dom    = in_data.req_type == dadm_pkg::REQ_DOMAIN;
  assign is_sep    = in_data.last || (in_data.data_byte == dadm_pkg::SEPARATOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_enable <= 1'b0;
      allow_mode   <= 1'b0;
      deny_enable  <= 1'b0;
      deny_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dadm_pkg::CFG_ALLOW_ENABLE: allow_enable <= cfg_data;
        dadm_pkg::CFG_ALLOW_MODE:   allow_mode   <= cfg_data;
        dadm_pkg::CFG_DENY_ENABLE:  deny_enable  <= cfg_data;
        dadm_pkg::CFG_DENY_MODE:    deny_mode    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A list byte arriving while no load is under way starts the list afresh.
  always_comb begin
    cnt_sel = is_allow ? allow_count : deny_count;
    cnt_eff = load_busy ? cnt_sel : '0;
    pos_eff = load_busy ? load_position : '0;
    pat_wr  = 1'b0;
    len_wr  = 1'b0;
    ovf_now = 1'b0;
    cnt_new = cnt_eff;
    pos_new = pos_eff;
    if (is_sep) begin
      pos_new = '0;
      if (cnt_eff < ECW'(MAX_ENTRIES)) begin
        len_wr  = in_acc && is_load;
        cnt_new = cnt_eff + ECW'(1);
      end else begin
        ovf_now = 1'b1;
      end
    end else if (cnt_eff >= ECW'(MAX_ENTRIES) || pos_eff >= PLW'(MAX_PATTERN_LEN)) begin
      ovf_now = 1'b1;
    end else begin
      pat_wr  = in_acc && is_load;
      pos_new = pos_eff + PLW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_count   <= '0;
      deny_count    <= '0;
      load_position <= '0;
      load_busy     <= 1'b0;
      domain_length <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (in_acc && is_load) begin
        load_position <= pos_new;
        load_busy     <= !in_data.last;
        if (is_allow) begin
          allow_count <= cnt_new;
        end else begin
          deny_count <= cnt_new;
        end
        // A load result carries and clears the shared flag.
        overflow_seen <= in_data.last ? 1'b0 : (overflow_seen | ovf_now);
      end else if (in_acc && is_dom) begin
        if (domain_length < DLW'(DOMAIN_MAX)) begin
          domain_length <= domain_length + DLW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end else if (verdict_go) begin
        overflow_seen <= 1'b0;
        domain_length <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_dom && domain_length < DLW'(DOMAIN_MAX)) begin
      dbuf[domain_length[DAW-1:0]] <= in_data.data_byte;
    end
    dom_q <= dbuf[addr[DAW-1:0]];
  end

  // The sweep walks every position per offset; offsets follow the deciding list's mode.
  assign sel_allow  = allow_enable;
  assign substr_sel = sel_allow ? allow_mode : deny_mode;
  assign addr       = {1'b0, off} + (DLW+1)'(k);
  assign sweep_end  = (k == PAW'(MAX_PATTERN_LEN - 1))
                      && (!substr_sel || (off == domain_length - DLW'(1)));
  assign verdict_go = (st == dadm_pkg::ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    st_next = st;
    unique case (st)
      dadm_pkg::ST_IDLE: begin
        if (in_acc && is_dom && in_data.last) begin
          st_next = (allow_enable || deny_enable) ? dadm_pkg::ST_SWEEP : dadm_pkg::ST_DONE;
        end
      end
      dadm_pkg::ST_SWEEP: begin
        if (sweep_end) begin
          st_next = dadm_pkg::ST_DRAIN;
        end
      end
      dadm_pkg::ST_DRAIN: begin
        if (drain == DRW'(MAX_ENTRIES + 3)) begin
          st_next = dadm_pkg::ST_DONE;
        end
      end
      dadm_pkg::ST_DONE: begin
        if (verdict_go) begin
          st_next = dadm_pkg::ST_IDLE;
        end
      end
      default: st_next = dadm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    clr = in_acc && is_dom && in_data.last;
    verdict = '0;
    verdict.result_kind = dadm_pkg::KIND_VERDICT;
    verdict.overflow    = overflow_seen;
    if (allow_enable) begin
      if (allow_hit) begin
        verdict.rule_hit = allow_mode ? dadm_pkg::HIT_ALLOW_SUB : dadm_pkg::HIT_ALLOW_EXACT;
      end else begin
        verdict.rule_hit = dadm_pkg::HIT_ALLOW_MISS;
        verdict.drop     = 1'b1;
      end
    end else if (deny_enable && deny_hit) begin
      verdict.rule_hit = deny_mode ? dadm_pkg::HIT_DENY_SUB : dadm_pkg::HIT_DENY_EXACT;
      verdict.drop     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= dadm_pkg::ST_IDLE;
      off   <= '0;
      k     <= '0;
      k1    <= '0;
      act1  <= 1'b0;
      dv1   <= 1'b0;
      drain <= '0;
    end else begin
      st   <= st_next;
      act1 <= st == dadm_pkg::ST_SWEEP;
      dv1  <= addr < {1'b0, domain_length};
      k1   <= k;
      if (st == dadm_pkg::ST_SWEEP) begin
        if (k == PAW'(MAX_PATTERN_LEN - 1)) begin
          k   <= '0;
          off <= off + DLW'(1);
        end else begin
          k <= k + PAW'(1);
        end
      end else begin
        k   <= '0;
        off <= '0;
      end
      drain <= (st == dadm_pkg::ST_DRAIN) ? drain + DRW'(1) : '0;
    end
  end

  assign sw.clr   = clr;
  assign sw.act   = act1;
  assign sw.dv    = dv1;
  assign sw.dbyte = dom_q;

  dadm_chain #(
    .MAX_ENTRIES(MAX_ENTRIES), .MAX_PATTERN_LEN(MAX_PATTERN_LEN), .DOMAIN_MAX(DOMAIN_MAX)
  ) u_allow (
    .clk(clk), .rst(rst),
    .wr_en(pat_wr && is_allow), .len_wr(len_wr && is_allow),
    .wr_idx(cnt_eff[EIW-1:0]), .wr_addr(pos_eff[PAW-1:0]),
    .wr_data(in_data.data_byte), .len_data(pos_eff),
    .count(allow_count), .substr(allow_mode), .dlen(domain_length),
    .k_rd(k), .k_cmp(k1), .sw(sw), .hit(allow_hit)
  );

  dadm_chain #(
    .MAX_ENTRIES(MAX_ENTRIES), .MAX_PATTERN_LEN(MAX_PATTERN_LEN), .DOMAIN_MAX(DOMAIN_MAX)
  ) u_deny (
    .clk(clk), .rst(rst),
    .wr_en(pat_wr && !is_allow), .len_wr(len_wr && !is_allow),
    .wr_idx(cnt_eff[EIW-1:0]), .wr_addr(pos_eff[PAW-1:0]),
    .wr_data(in_data.data_byte), .len_data(pos_eff),
    .count(deny_count), .substr(deny_mode), .dlen(domain_length),
    .k_rd(k), .k_cmp(k1), .sw(sw), .hit(deny_hit)
  );

  // The output register holds one item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && is_load && in_data.last) begin
      out_valid <= 1'b1;
    end else if (verdict_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_load && in_data.last) begin
      out_data             <= '0;
      out_data.result_kind <= dadm_pkg::KIND_LOAD;
      out_data.overflow    <= overflow_seen | ovf_now;
    end else if (verdict_go) begin
      out_data <= verdict;
    end
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (st != dadm_pkg::ST_IDLE) |-> !in_ready) else $error("input taken during sweep");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_load && in_data.last) |=> (out_valid && !out_data.result_kind
      && !out_data.drop)) else $error("load result missing");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    verdict_go |=> (out_valid && out_data.result_kind && st == dadm_pkg::ST_IDLE))
    else $error("verdict not delivered");

  a_domain_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_dom && in_data.last) |=>
      (st == dadm_pkg::ST_SWEEP || st == dadm_pkg::ST_DONE)) else $error("no sweep");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the domain allow/deny matcher with a predictor of list loads and verdicts.
`timescale 1ns / 1ps
module tb;

  localparam int NENT = dadm_pkg::MAX_ENTRIES_DEF;
  localparam int PLEN = dadm_pkg::MAX_PATTERN_LEN_DEF;
  localparam int DMAX = dadm_pkg::DOMAIN_MAX_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  dadm_pkg::in_item_t in_data;
  dadm_pkg::out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic cfg_data;

  domain_allow_deny_matcher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: a private copy of the lists, the domain buffer and the registers.
  logic       m_allow_en, m_allow_sub, m_deny_en, m_deny_sub;
  logic [7:0] m_allow_pat [NENT][PLEN];
  logic [7:0] m_deny_pat [NENT][PLEN];
  int         m_allow_len [NENT];
  int         m_deny_len [NENT];
  int         m_allow_cnt, m_deny_cnt, m_load_pos;
  bit         m_load_busy, m_ovf;
  logic [7:0] m_dom [DMAX];
  int         m_dom_len;

  dadm_pkg::out_item_t expected_results[$];
  int  errors;
  int  mismatches;
  int  send_idle_pct, recv_idle_pct;
  int  items_sent;
  int  sel;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A run that hangs ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Does one entry of a list match the buffered domain?
  function automatic bit entry_matches(input bit is_allow, input int e, input bit sub);
    int n;
    bit ok;
    n = is_allow ? m_allow_len[e] : m_deny_len[e];
    if (!sub) begin
      if (n != m_dom_len) return 0;
      for (int k = 0; k < n; k++)
        if (m_dom[k] != (is_allow ? m_allow_pat[e][k] : m_deny_pat[e][k])) return 0;
      return 1;
    end
    if (n == 0 || n > m_dom_len) return 0;
    for (int off = 0; off + n <= m_dom_len; off++) begin
      ok = 1;
      for (int k = 0; k < n; k++)
        if (m_dom[off + k] != (is_allow ? m_allow_pat[e][k] : m_deny_pat[e][k])) ok = 0;
      if (ok) return 1;
    end
    return 0;
  endfunction

  function automatic bit list_matches(input bit is_allow, input bit sub);
    int cnt;
    cnt = is_allow ? m_allow_cnt : m_deny_cnt;
    for (int e = 0; e < cnt && e < NENT; e++)
      if (entry_matches(is_allow, e, sub)) return 1;
    return 0;
  endfunction

  // One list byte: a space or the byte marked last closes the entry, and the
  // last byte itself is discarded.
  function automatic void load_list_byte(input bit is_allow, input logic [7:0] b,
                                         input bit lst);
    int cnt;
    if (!m_load_busy) begin
      if (is_allow) m_allow_cnt = 0; else m_deny_cnt = 0;
      m_load_pos = 0;
      m_load_busy = 1;
    end
    cnt = is_allow ? m_allow_cnt : m_deny_cnt;
    if (lst || b == dadm_pkg::SEPARATOR) begin
      if (cnt < NENT) begin
        if (is_allow) begin
          m_allow_len[cnt] = m_load_pos; m_allow_cnt++;
        end else begin
          m_deny_len[cnt] = m_load_pos; m_deny_cnt++;
        end
      end else begin
        m_ovf = 1;
      end
      m_load_pos = 0;
      if (lst) m_load_busy = 0;
      return;
    end
    if (cnt >= NENT || m_load_pos >= PLEN) begin
      m_ovf = 1;
      return;
    end
    if (is_allow) m_allow_pat[cnt][m_load_pos] = b;
    else m_deny_pat[cnt][m_load_pos] = b;
    m_load_pos++;
  endfunction

  // Works out what an accepted item produces and queues it.
  function automatic void predict_item(input dadm_pkg::in_item_t it);
    dadm_pkg::out_item_t r;
    r = '0;
    case (it.req_type)
      dadm_pkg::REQ_ALLOW_LOAD, dadm_pkg::REQ_DENY_LOAD: begin
        load_list_byte(it.req_type == dadm_pkg::REQ_ALLOW_LOAD, it.data_byte, it.last);
        if (!it.last) return;
        r.result_kind = dadm_pkg::KIND_LOAD;
        r.rule_hit = dadm_pkg::HIT_NONE;
      end
      dadm_pkg::REQ_DOMAIN: begin
        if (m_dom_len < DMAX) begin
          m_dom[m_dom_len] = it.data_byte;
          m_dom_len++;
        end else begin
          m_ovf = 1;
        end
        if (!it.last) return;
        r.result_kind = dadm_pkg::KIND_VERDICT;
        r.rule_hit = dadm_pkg::HIT_NONE;
        if (m_allow_en) begin
          if (list_matches(1, m_allow_sub)) begin
            r.rule_hit = m_allow_sub ? dadm_pkg::HIT_ALLOW_SUB : dadm_pkg::HIT_ALLOW_EXACT;
          end else begin
            r.rule_hit = dadm_pkg::HIT_ALLOW_MISS;
            r.drop = 1;
          end
        end else if (m_deny_en) begin
          if (list_matches(0, m_deny_sub)) begin
            r.rule_hit = m_deny_sub ? dadm_pkg::HIT_DENY_SUB : dadm_pkg::HIT_DENY_EXACT;
            r.drop = 1;
          end
        end
        m_dom_len = 0;
      end
      default: return;
    endcase
    r.overflow = m_ovf;
    m_ovf = 0;
    expected_results.push_back(r);
  endfunction

  // Output side: random back-pressure, comparison against the oldest expectation.
  always @(negedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        if (out_data !== expected_results[0]) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", expected_results[0], out_data);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // Valid stays high from one item to the next unless the sender idles, so it
  // gets at most one assignment per falling edge.
  task automatic send_item(input dadm_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_reg(input logic [2:0] idx, input logic val);
    while (expected_results.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      dadm_pkg::CFG_ALLOW_ENABLE: m_allow_en = val;
      dadm_pkg::CFG_ALLOW_MODE:   m_allow_sub = val;
      dadm_pkg::CFG_DENY_ENABLE:  m_deny_en = val;
      default:                    m_deny_sub = val;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input logic ae, input logic am, input logic de, input logic dm);
    in_valid <= 1'b0;
    write_reg(dadm_pkg::CFG_ALLOW_ENABLE, ae);
    write_reg(dadm_pkg::CFG_ALLOW_MODE, am);
    write_reg(dadm_pkg::CFG_DENY_ENABLE, de);
    write_reg(dadm_pkg::CFG_DENY_MODE, dm);
    cfg_valid <= 1'b0;
  endtask

  // Small alphabet so random domains and patterns actually meet; now and then
  // any byte value, so every data bit toggles.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));
    return 8'h61 + 8'($urandom_range(3));
  endfunction

  // A list load with random entries; occasionally an over-long entry or too many entries.
  task automatic send_list(input dadm_pkg::req_t kind);
    int nent, len;
    dadm_pkg::in_item_t it;
    nent = ($urandom_range(9) == 0) ? NENT + 2 : $urandom_range(1, 4);
    for (int e = 0; e < nent; e++) begin
      len = ($urandom_range(19) == 0) ? PLEN + 3 : $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        it.req_type = kind;
        it.data_byte = pick_char();
        if (it.data_byte == dadm_pkg::SEPARATOR) it.data_byte = 8'h61;
        it.last = 1'b0;
        send_item(it);
      end
      if (e != nent - 1) begin
        it.req_type = kind; it.data_byte = dadm_pkg::SEPARATOR; it.last = 1'b0;
        send_item(it);
      end
    end
    it.req_type = kind; it.data_byte = 8'($urandom_range(255)); it.last = 1'b1;
    send_item(it);
  endtask

  task automatic send_domain();
    int len;
    dadm_pkg::in_item_t it;
    len = ($urandom_range(49) == 0) ? DMAX + 2 : $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      it.req_type = dadm_pkg::REQ_DOMAIN;
      it.data_byte = pick_char();
      it.last = (k == len - 1);
      send_item(it);
    end
  endtask

  // Directed rows. check marks rows whose result is typed in here.
  typedef struct {
    dadm_pkg::in_item_t   it;
    bit                   check;
    dadm_pkg::out_item_t  want;
  } row_t;
  row_t plan[$];

  function automatic void add_row(input dadm_pkg::req_t k, input logic [7:0] b,
                                  input logic l, input bit chk,
                                  input dadm_pkg::out_item_t w);
    row_t r;
    r.it.req_type = k; r.it.data_byte = b; r.it.last = l;
    r.check = chk; r.want = w;
    plan.push_back(r);
  endfunction

  initial begin
    errors = 0; mismatches = 0; items_sent = 0;
    send_idle_pct = 34; recv_idle_pct = 62;
    rst = 1'b1;
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = 1'b0;
    m_allow_en = 0; m_allow_sub = 0; m_deny_en = 0; m_deny_sub = 0;
    m_allow_cnt = 0; m_deny_cnt = 0; m_load_pos = 0;
    m_load_busy = 0; m_ovf = 0; m_dom_len = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With nothing enabled, every domain is accepted with no rule hit.
    add_row(dadm_pkg::REQ_DOMAIN, 8'h00, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_DOMAIN, 8'hFF, 1'b1, 1,
            '{dadm_pkg::KIND_VERDICT, 1'b0, dadm_pkg::HIT_NONE, 1'b0});
    // Unused request type gives nothing.
    add_row(dadm_pkg::REQ_UNUSED, 8'hFF, 1'b1, 0, '0);
    // Allow list "ab", an empty entry, then "b"; the last byte is discarded.
    add_row(dadm_pkg::REQ_ALLOW_LOAD, 8'h61, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_ALLOW_LOAD, 8'h62, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_ALLOW_LOAD, dadm_pkg::SEPARATOR, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_ALLOW_LOAD, dadm_pkg::SEPARATOR, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_ALLOW_LOAD, 8'h62, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_ALLOW_LOAD, 8'h00, 1'b1, 1,
            '{dadm_pkg::KIND_LOAD, 1'b0, dadm_pkg::HIT_NONE, 1'b0});
    // Deny list "ab" then "xab".
    add_row(dadm_pkg::REQ_DENY_LOAD, 8'h61, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_DENY_LOAD, 8'h62, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_DENY_LOAD, dadm_pkg::SEPARATOR, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_DENY_LOAD, 8'h78, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_DENY_LOAD, 8'h61, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_DENY_LOAD, 8'h62, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_DENY_LOAD, 8'hFF, 1'b1, 1,
            '{dadm_pkg::KIND_LOAD, 1'b0, dadm_pkg::HIT_NONE, 1'b0});
    add_row(dadm_pkg::REQ_DOMAIN, 8'h61, 1'b0, 0, '0);
    add_row(dadm_pkg::REQ_DOMAIN, 8'h62, 1'b1, 0, '0);

    foreach (plan[i]) begin
      send_item(plan[i].it);
      if (plan[i].check && plan[i].want !== expected_results[$]) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: typed %p, predicted %p", i, plan[i].want,
                   expected_results[$]);
      end
    end

    // Sweep of register settings, extremes first, each followed by a random mix
    // of list loads, unused requests and domains.
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 6) begin send_idle_pct = 62; recv_idle_pct = 34; end
      if (ph == 11) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph == 0) set_regs(1, 1, 1, 1);
      else if (ph == 1) set_regs(1, 0, 0, 0);
      else if (ph == 2) set_regs(0, 0, 1, 0);
      else if (ph == 3) set_regs(0, 1, 1, 1);
      else if (ph == 4) set_regs(0, 0, 0, 0);
      else set_regs($urandom_range(1), $urandom_range(1), $urandom_range(1),
                    $urandom_range(1));
      repeat (6) begin
        sel = $urandom_range(9);
        if (sel < 2) send_list(dadm_pkg::REQ_ALLOW_LOAD);
        else if (sel < 4) send_list(dadm_pkg::REQ_DENY_LOAD);
        else if (sel == 4)
          send_item('{dadm_pkg::REQ_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1))});
        else send_domain();
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
